[hdl/number_literal_parser_macros.svh]
// Assertion macros shared by the number literal parser RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef NUMBER_LITERAL_PARSER_MACROS_SVH
`define NUMBER_LITERAL_PARSER_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define NLP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while the active-low reset is asserted.
`define NLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/nlp_pkg.sv]
// Shared types and codes for the number literal parser.
// Depends on nothing; used by nlp_step and number_literal_parser.
`timescale 1ns / 1ps

package nlp_pkg;

    localparam int CH_W     = 8;
    localparam int VALUE_W  = 32;
    localparam int KIND_W   = 2;
    localparam int PHASE_W  = 3;

    // Result kinds held in the mode register. Code 3 behaves as unsigned 32-bit.
    localparam logic [KIND_W-1:0] KIND_U32    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_U16    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SIGNED = 2'd2;

    // Parse phases.
    localparam logic [PHASE_W-1:0] PH_START  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_NUMBEG = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ZERO   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DEC    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_HEX    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_BIN    = 3'd5;
    localparam logic [PHASE_W-1:0] PH_ERR    = 3'd6;

    localparam logic [CH_W-1:0] CH_NUL = 8'h00;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [VALUE_W-1:0] acc;
        logic               seen_digit;
        logic               negative;
    } nlp_state_t;

    typedef struct packed {
        logic               fire;
        logic [VALUE_W-1:0] value;
        logic               ok;
    } nlp_result_t;

endpackage

[hdl/number_literal_parser.sv]
// Top level of the ASCII integer literal parser: parse state, mode register, result register.
// Depends on nlp_pkg, nlp_step and number_literal_parser_macros.svh.
`timescale 1ns / 1ps

// The parser takes one ASCII character per beat on the s_ channel and turns a
// NUL-terminated string into one result beat on the m_ channel: a 32-bit value
// and an ok flag. Decimal, 0x/0X hexadecimal and 0b/0B binary forms are
// understood; the accumulator wraps modulo 2^32. Any syntax error, or a value
// above 0xFFFF in 16-bit mode, gives ok low and a value of zero. In signed mode
// one leading minus is accepted and the result is the two's complement
// negation. Characters other than NUL produce no result beat. The block takes
// one character every clock cycle: the state update is a single pass of
// logic into the parse registers, and the result of a NUL beat appears in the
// output register on the next cycle. s_ready stays high while that register is
// empty or is being emptied in the same cycle, so a result that waits on
// m_ready holds off every input beat until it is taken. The mode register is
// written through cfg_wr_en and cfg_wr_data and should change only between
// strings.
module number_literal_parser (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [nlp_pkg::KIND_W-1:0]     cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [nlp_pkg::CH_W-1:0]       s_ch,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [nlp_pkg::VALUE_W-1:0]    m_value,
    output logic                           m_ok
);

`include "number_literal_parser_macros.svh"

    // Mode register selecting the result kind.
    logic [nlp_pkg::KIND_W-1:0] kind_reg;

    // Parse state carried from one character to the next.
    nlp_pkg::nlp_state_t state_reg;
    nlp_pkg::nlp_state_t state_next;
    nlp_pkg::nlp_result_t step_result;

    // Output register; it holds one finished result until it is taken.
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [nlp_pkg::VALUE_W-1:0] m_value_reg;
    logic                        m_ok_reg;

    logic s_beat;

    // A new character may enter whenever the result slot is free or draining.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_beat  = s_valid && s_ready;

    nlp_step u_step (
        .state_cur (state_reg),
        .ch        (s_ch),
        .kind      (kind_reg),
        .state_nxt (state_next),
        .result    (step_result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_beat && step_result.fire) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg             <= nlp_pkg::KIND_U32;
            state_reg.phase      <= nlp_pkg::PH_START;
            state_reg.acc        <= '0;
            state_reg.seen_digit <= 1'b0;
            state_reg.negative   <= 1'b0;
            m_valid_reg          <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                kind_reg <= cfg_wr_data;
            end
            if (s_beat) begin
                state_reg <= state_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // The result payload needs no reset; it is qualified by m_valid_reg.
    always_ff @(posedge aclk) begin
        if (s_beat && step_result.fire) begin
            m_value_reg <= step_result.value;
            m_ok_reg    <= step_result.ok;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_ok    = m_ok_reg;

    // A NUL beat always leaves a result waiting in the output register.
    `NLP_ASSERT_NEXT(a_nul_gives_result, aclk, aresetn, s_beat && (s_ch == nlp_pkg::CH_NUL), m_valid, "NUL beat did not produce a result")
    // A NUL beat returns the parse state to the start of a string.
    `NLP_ASSERT_NEXT(a_nul_clears_state, aclk, aresetn, s_beat && (s_ch == nlp_pkg::CH_NUL), (state_reg.phase == nlp_pkg::PH_START) && (state_reg.acc == '0) && !state_reg.negative, "parse state not cleared after NUL")
    // A failed parse reports a zero value.
    `NLP_ASSERT_IMPLY(a_err_value_zero, aclk, aresetn, m_valid && !m_ok, m_value == '0, "error result with nonzero value")
    // A waiting result that is not taken must not be overwritten.
    `NLP_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_value) && $stable(m_ok), "pending result changed before it was taken")

endmodule

[hdl/nlp_step.sv]
// Combinational next-state and result logic for one character of the parser.
// Depends on nlp_pkg.
`timescale 1ns / 1ps

module nlp_step (
    input  nlp_pkg::nlp_state_t            state_cur,
    input  logic [nlp_pkg::CH_W-1:0]       ch,
    input  logic [nlp_pkg::KIND_W-1:0]     kind,
    output nlp_pkg::nlp_state_t            state_nxt,
    output nlp_pkg::nlp_result_t           result
);

    localparam logic [nlp_pkg::CH_W-1:0]    CH_DIGIT0 = 8'h30;
    localparam logic [nlp_pkg::CH_W-1:0]    CH_DIGIT1 = 8'h31;
    localparam logic [nlp_pkg::CH_W-1:0]    CH_DIGIT9 = 8'h39;
    localparam logic [nlp_pkg::CH_W-1:0]    CH_MINUS  = 8'h2D;
    localparam logic [nlp_pkg::CH_W-1:0]    CH_LOW_A  = 8'h61;
    localparam logic [nlp_pkg::CH_W-1:0]    CH_LOW_B  = 8'h62;
    localparam logic [nlp_pkg::CH_W-1:0]    CH_LOW_F  = 8'h66;
    localparam logic [nlp_pkg::CH_W-1:0]    CH_LOW_X  = 8'h78;
    localparam logic [nlp_pkg::CH_W-1:0]    CASE_BIT  = 8'h20;
    localparam logic [nlp_pkg::VALUE_W-1:0] U16_MAX   = 32'h0000_FFFF;
    localparam logic [3:0]                  HEX_ALPHA_OFS = 4'd9;

    logic [nlp_pkg::CH_W-1:0]    ch_low;
    logic                        is_dec;
    logic                        is_alpha;
    logic                        is_bin;
    logic [3:0]                  dig_val;
    logic [nlp_pkg::VALUE_W-1:0] dig_ext;
    logic [nlp_pkg::VALUE_W-1:0] acc_x10;
    logic                        end_ok;
    logic [nlp_pkg::VALUE_W-1:0] end_val;

    assign ch_low   = ch | CASE_BIT;
    assign is_dec   = (ch >= CH_DIGIT0) && (ch <= CH_DIGIT9);
    assign is_alpha = (ch_low >= CH_LOW_A) && (ch_low <= CH_LOW_F);
    assign is_bin   = (ch == CH_DIGIT0) || (ch == CH_DIGIT1);
    // Letters a-f carry 1-6 in the low nibble, so adding nine gives 10-15.
    assign dig_val  = is_dec ? ch[3:0] : (ch[3:0] + HEX_ALPHA_OFS);
    assign dig_ext  = {{(nlp_pkg::VALUE_W-4){1'b0}}, dig_val};
    assign acc_x10  = (state_cur.acc << 3) + (state_cur.acc << 1);

    always_comb begin
        end_ok = (state_cur.phase == nlp_pkg::PH_ZERO) ||
                 (((state_cur.phase == nlp_pkg::PH_DEC) ||
                   (state_cur.phase == nlp_pkg::PH_HEX) ||
                   (state_cur.phase == nlp_pkg::PH_BIN)) && state_cur.seen_digit);
        end_val = state_cur.acc;
        if (end_ok && (kind == nlp_pkg::KIND_U16) && (state_cur.acc > U16_MAX)) begin
            end_ok = 1'b0;
        end
        if (end_ok && (kind == nlp_pkg::KIND_SIGNED) && state_cur.negative) begin
            end_val = '0 - state_cur.acc;
        end
        if (!end_ok) begin
            end_val = '0;
        end
    end

    always_comb begin
        state_nxt    = state_cur;
        result.fire  = 1'b0;
        result.value = end_val;
        result.ok    = end_ok;
        if (ch == nlp_pkg::CH_NUL) begin
            result.fire          = 1'b1;
            state_nxt.phase      = nlp_pkg::PH_START;
            state_nxt.acc        = '0;
            state_nxt.seen_digit = 1'b0;
            state_nxt.negative   = 1'b0;
        end else begin
            unique case (state_cur.phase) inside
                nlp_pkg::PH_START, nlp_pkg::PH_NUMBEG: begin
                    if ((ch == CH_MINUS) && (state_cur.phase == nlp_pkg::PH_START) &&
                        (kind == nlp_pkg::KIND_SIGNED)) begin
                        state_nxt.negative = 1'b1;
                        state_nxt.phase    = nlp_pkg::PH_NUMBEG;
                    end else if (ch == CH_DIGIT0) begin
                        state_nxt.acc   = '0;
                        state_nxt.phase = nlp_pkg::PH_ZERO;
                    end else if (is_dec) begin
                        state_nxt.acc        = dig_ext;
                        state_nxt.seen_digit = 1'b1;
                        state_nxt.phase      = nlp_pkg::PH_DEC;
                    end else begin
                        state_nxt.phase = nlp_pkg::PH_ERR;
                    end
                end
                nlp_pkg::PH_ZERO: begin
                    if (ch_low == CH_LOW_B) begin
                        state_nxt.seen_digit = 1'b0;
                        state_nxt.phase      = nlp_pkg::PH_BIN;
                    end else if (ch_low == CH_LOW_X) begin
                        state_nxt.seen_digit = 1'b0;
                        state_nxt.phase      = nlp_pkg::PH_HEX;
                    end else if (is_dec) begin
                        state_nxt.acc        = dig_ext;
                        state_nxt.seen_digit = 1'b1;
                        state_nxt.phase      = nlp_pkg::PH_DEC;
                    end else begin
                        state_nxt.phase = nlp_pkg::PH_ERR;
                    end
                end
                nlp_pkg::PH_DEC: begin
                    if (is_dec) begin
                        state_nxt.acc        = acc_x10 + dig_ext;
                        state_nxt.seen_digit = 1'b1;
                    end else begin
                        state_nxt.phase = nlp_pkg::PH_ERR;
                    end
                end
                nlp_pkg::PH_HEX: begin
                    if (is_dec || is_alpha) begin
                        state_nxt.acc        = (state_cur.acc << 4) | dig_ext;
                        state_nxt.seen_digit = 1'b1;
                    end else begin
                        state_nxt.phase = nlp_pkg::PH_ERR;
                    end
                end
                nlp_pkg::PH_BIN: begin
                    if (is_bin) begin
                        state_nxt.acc        = (state_cur.acc << 1) | dig_ext;
                        state_nxt.seen_digit = 1'b1;
                    end else begin
                        state_nxt.phase = nlp_pkg::PH_ERR;
                    end
                end
                default: begin
                    state_nxt.phase = nlp_pkg::PH_ERR;
                end
            endcase
        end
    end

endmodule

[tb/tb_number_literal_parser.sv]
// Self-checking testbench for number_literal_parser: directed literals, then random strings.
// Depends on nlp_pkg and the number_literal_parser RTL; needs no files or arguments.
`timescale 1ns / 1ps

// The bench feeds NUL-terminated ASCII strings one character per beat on the s_ channel.
// Both sides of the block throttle themselves at random. Every accepted character also goes
// through an in-bench literal parser. That parser queues the value and ok flag that each NUL
// should yield. A monitor pops that queue for every result beat on the m_ channel.
module tb_number_literal_parser;
    import nlp_pkg::*;

    localparam logic [CH_W-1:0]    CASE_BIT   = 8'h20;
    localparam logic [VALUE_W-1:0] U16_MAX    = 32'h0000_FFFF;
    localparam logic [VALUE_W-1:0] DEC_RADIX  = 32'd10;
    localparam logic [KIND_W-1:0]  KIND_UNUSED = 2'd3;
    localparam int                 MAX_WAIT   = 19;
    localparam int                 SETTLE     = 4;
    localparam int                 RANDOM_CHARS = 580;

    typedef logic [CH_W-1:0] char_q_t[$];

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               ok;
    } parse_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [KIND_W-1:0]    cfg_wr_data = KIND_U32;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [CH_W-1:0]      s_ch = CH_NUL;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [VALUE_W-1:0]   m_value;
    logic                 m_ok;

    // Mirror of the parse state and the mode register, kept in step with every accepted beat.
    logic [PHASE_W-1:0]   lit_phase = PH_START;
    logic [VALUE_W-1:0]   lit_acc = '0;
    logic                 lit_seen_digit = 1'b0;
    logic                 lit_negative = 1'b0;
    logic [KIND_W-1:0]    lit_kind = KIND_U32;

    parse_result_t        pending_results[$];
    int                   mismatch_count = 0;
    int                   chars_sent = 0;
    bit                   throttle_tx = 1'b1;
    bit                   throttle_rx = 1'b1;
    int                   rx_wait = 0;

    number_literal_parser dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_ch        (s_ch),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_ok        (m_ok)
    );

    initial begin
        forever begin
            #4 aclk = ~aclk;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Digit value of c in the given radix, or -1 when c is no digit of that radix.
    function automatic int digit_value(input logic [CH_W-1:0] c, input int radix);
        int d;
        d = -1;
        if (c >= "0" && c <= "9") begin
            d = int'(c) - int'("0");
        end else if (c >= "a" && c <= "f") begin
            d = int'(c) - int'("a") + 10;
        end else if (c >= "A" && c <= "F") begin
            d = int'(c) - int'("A") + 10;
        end
        if (d >= radix) begin
            d = -1;
        end
        return d;
    endfunction

    // Advances the mirrored parse by one accepted character. A NUL closes the string and
    // queues the result it must produce. The range check and the negation use the mode
    // in force at the NUL.
    task automatic parse_char(input logic [CH_W-1:0] c);
        int            d;
        parse_result_t r;
        if (c == CH_NUL) begin
            r.ok = (lit_phase == PH_ZERO) ||
                   ((lit_phase inside {PH_DEC, PH_HEX, PH_BIN}) && lit_seen_digit);
            r.value = lit_acc;
            if (r.ok && lit_kind == KIND_U16 && r.value > U16_MAX) begin
                r.ok = 1'b0;
            end
            if (r.ok && lit_kind == KIND_SIGNED && lit_negative) begin
                r.value = -r.value;
            end
            if (!r.ok) begin
                r.value = '0;
            end
            pending_results.push_back(r);
            lit_phase = PH_START;
            lit_acc = '0;
            lit_seen_digit = 1'b0;
            lit_negative = 1'b0;
        end else begin
            d = digit_value(c, 10);
            case (lit_phase)
                PH_START, PH_NUMBEG: begin
                    // One minus is allowed, and only as the first character in signed mode.
                    if (c == "-" && lit_phase == PH_START && lit_kind == KIND_SIGNED) begin
                        lit_negative = 1'b1;
                        lit_phase = PH_NUMBEG;
                    end else if (c == "0") begin
                        lit_acc = '0;
                        lit_phase = PH_ZERO;
                    end else if (d >= 0) begin
                        lit_acc = VALUE_W'(d);
                        lit_seen_digit = 1'b1;
                        lit_phase = PH_DEC;
                    end else begin
                        lit_phase = PH_ERR;
                    end
                end
                PH_ZERO: begin
                    // After a leading zero, a radix letter of either case starts a prefix.
                    if ((c | CASE_BIT) == "b") begin
                        lit_seen_digit = 1'b0;
                        lit_phase = PH_BIN;
                    end else if ((c | CASE_BIT) == "x") begin
                        lit_seen_digit = 1'b0;
                        lit_phase = PH_HEX;
                    end else if (d >= 0) begin
                        lit_acc = VALUE_W'(d);
                        lit_seen_digit = 1'b1;
                        lit_phase = PH_DEC;
                    end else begin
                        lit_phase = PH_ERR;
                    end
                end
                PH_DEC: begin
                    if (d >= 0) begin
                        lit_acc = lit_acc * DEC_RADIX + VALUE_W'(d);
                        lit_seen_digit = 1'b1;
                    end else begin
                        lit_phase = PH_ERR;
                    end
                end
                PH_HEX: begin
                    d = digit_value(c, 16);
                    if (d >= 0) begin
                        lit_acc = {lit_acc[VALUE_W-5:0], 4'(d)};
                        lit_seen_digit = 1'b1;
                    end else begin
                        lit_phase = PH_ERR;
                    end
                end
                PH_BIN: begin
                    d = digit_value(c, 2);
                    if (d >= 0) begin
                        lit_acc = {lit_acc[VALUE_W-2:0], 1'(d)};
                        lit_seen_digit = 1'b1;
                    end else begin
                        lit_phase = PH_ERR;
                    end
                end
                default: begin
                    // After an error, everything up to the NUL is ignored.
                    lit_phase = PH_ERR;
                end
            endcase
        end
    endtask

    // Sends one character beat. Valid drops only when a gap is drawn, so a back-to-back beat
    // keeps valid high with just the new payload. All handshake signals are sampled at the
    // edge, before that edge's updates land.
    task automatic send_char(input logic [CH_W-1:0] c);
        int gap;
        gap = throttle_tx ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ch <= c;
        do @(posedge aclk); while (!s_ready);
        parse_char(c);
        chars_sent++;
    endtask

    task automatic send_literal(input char_q_t chars);
        foreach (chars[i]) begin
            send_char(chars[i]);
        end
        send_char(CH_NUL);
    endtask

    task automatic send_text(input string s);
        char_q_t chars;
        for (int i = 0; i < s.len(); i++) begin
            chars.push_back(s[i]);
        end
        send_literal(chars);
    endtask

    // Stops sending and waits until every queued result has come back.
    // The settle wait added afterward covers the result register.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // The mode register is written only between strings, with nothing in flight.
    task automatic set_kind(input logic [KIND_W-1:0] kind);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= kind;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        lit_kind = kind;
    endtask

    function automatic logic [CH_W-1:0] dec_digit();
        return CH_W'(int'("0") + $urandom_range(0, 9));
    endfunction

    // Builds a random string, mostly well-formed literals with random digits.
    // The rest are literals with a stray byte, bare prefixes and pure noise.
    task automatic build_literal(output char_q_t chars);
        int form;
        int n;
        int d;
        chars = {};
        if ($urandom_range(0, 3) == 0) begin
            chars.push_back("-");
            if ($urandom_range(0, 15) == 0) begin
                chars.push_back("-");
            end
        end
        form = $urandom_range(0, 99);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
        if (form < 25) begin
            repeat (n) chars.push_back(dec_digit());
        end else if (form < 45) begin
            chars.push_back("0");
            chars.push_back($urandom_range(0, 1) ? "x" : "X");
            if ($urandom_range(0, 15) == 0) begin
                n = 0;
            end
            repeat (n) begin
                d = $urandom_range(0, 15);
                if (d < 10) begin
                    chars.push_back(CH_W'(int'("0") + d));
                end else begin
                    chars.push_back(CH_W'(int'($urandom_range(0, 1) ? "a" : "A") + d - 10));
                end
            end
        end else if (form < 60) begin
            chars.push_back("0");
            chars.push_back($urandom_range(0, 1) ? "b" : "B");
            n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 34);
            repeat (n) chars.push_back($urandom_range(0, 1) ? "1" : "0");
        end else if (form < 65) begin
            repeat ($urandom_range(1, 3)) chars.push_back("0");
        end else if (form < 80) begin
            repeat (n) chars.push_back(dec_digit());
            chars.insert($urandom_range(0, chars.size()), CH_W'($urandom_range(1, 255)));
        end else begin
            repeat ($urandom_range(0, 6)) chars.push_back(CH_W'($urandom_range(1, 255)));
        end
    endtask

    // Result monitor. It checks each result beat against the oldest expectation, then draws
    // how long to hold ready low for the next result. That countdown runs only while a
    // result waits.
    initial begin
        parse_result_t exp_r;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value=%h ok=%b",
                                              m_value, m_ok));
                end else begin
                    exp_r = pending_results.pop_front();
                    if (m_value !== exp_r.value) begin
                        report_mismatch($sformatf("value %h, expected %h",
                                                  m_value, exp_r.value));
                    end
                    if (m_ok !== exp_r.ok) begin
                        report_mismatch($sformatf("ok %b, expected %b", m_ok, exp_r.ok));
                    end
                end
                rx_wait = throttle_rx ? $urandom_range(0, MAX_WAIT) : 0;
            end else if (m_valid && rx_wait > 0) begin
                rx_wait--;
            end
            m_ready <= (rx_wait == 0);
        end
    end

    // Plain unsigned mode. It covers all three radixes with both prefix cases, the full
    // 32-bit range and wrap-around, leading zeros, and the empty string. It also covers bare
    // prefixes, bad digits, a minus outside signed mode, and bytes with the top bit set.
    task automatic test_unsigned_forms();
        char_q_t raw;
        set_kind(KIND_U32);
        send_text("");
        send_text("0");
        send_text("007");
        send_text("4294967295");
        send_text("4294967296");
        send_text("0xFFFFFFFF");
        send_text("0XdeadBEEF");
        send_text("0x123456789");
        send_text("0b101");
        send_text("0B11111111111111111111111111111111");
        send_text("0x");
        send_text("0b");
        send_text("0b12");
        send_text("0xg1");
        send_text("12a3");
        send_text("-5");
        raw = {8'h31, 8'h80, 8'h32};
        send_literal(raw);
        raw = {8'hFF};
        send_literal(raw);
    endtask

    // In 16-bit mode the value may reach 0xFFFF but not go past it.
    task automatic test_u16_range();
        set_kind(KIND_U16);
        send_text("65535");
        send_text("65536");
        send_text("0xFFFF");
        send_text("0x10000");
        send_text("0b1");
        send_text("-1");
    endtask

    // In signed mode, a single leading minus negates the value. A bare or doubled minus is
    // an error, and so is a minus anywhere else. The most negative value wraps onto itself.
    task automatic test_signed();
        set_kind(KIND_SIGNED);
        send_text("-");
        send_text("-0");
        send_text("-2147483648");
        send_text("-0x80000000");
        send_text("-0b101");
        send_text("--5");
        send_text("5-");
        send_text("-007");
        send_text("123");
        send_text("-0x");
    endtask

    // The unused mode code behaves like plain unsigned.
    task automatic test_kind_three();
        set_kind(KIND_UNUSED);
        send_text("-7");
        send_text("70000");
        send_text("0x1F");
    endtask

    // Back-to-back NULs and short strings. First the result side stalls, so the input is
    // held off. Then both sides run flat out.
    task automatic test_back_to_back();
        set_kind(KIND_U32);
        throttle_tx = 1'b0;
        throttle_rx = 1'b1;
        for (int i = 0; i < 20; i++) begin
            send_text((i % 2 == 0) ? "" : "9");
        end
        throttle_rx = 1'b0;
        for (int i = 0; i < 20; i++) begin
            send_text((i % 3 == 0) ? "" : "0x7");
        end
        throttle_tx = 1'b1;
        throttle_rx = 1'b1;
    endtask

    // Random strings. Every twelve strings, the bench waits for all results, then switches to
    // a random mode. Throttling on each side is turned on or off per string.
    task automatic test_random_strings();
        char_q_t chars;
        int      first_char;
        int      strings;
        first_char = chars_sent;
        strings = 0;
        while (chars_sent - first_char < RANDOM_CHARS) begin
            if (strings % 12 == 0) begin
                set_kind(KIND_W'($urandom_range(0, 3)));
            end
            throttle_tx = ($urandom_range(0, 3) != 0);
            throttle_rx = ($urandom_range(0, 3) != 0);
            build_literal(chars);
            send_literal(chars);
            strings++;
        end
        throttle_tx = 1'b1;
        throttle_rx = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_unsigned_forms();
        test_u16_range();
        test_signed();
        test_kind_three();
        test_back_to_back();
        test_random_strings();
        drain();
        repeat (10) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake. This is far beyond the slowest legal run.
    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/nlp_pkg.sv
hdl/nlp_step.sv
hdl/number_literal_parser.sv
tb/tb_number_literal_parser.sv
